[rtl/stok_pkg.sv]
// ============================================================================
// Source tokenizer package
// Shared widths, token and error codes, scanner state types and the
// character classification and keyword tables used by the tokenizer.
// ============================================================================
package stok_pkg;

   // Field widths of the input and result transfers.
   localparam int BYTE_W = 8;
   localparam int NUM_W  = 64;
   localparam int KIND_W = 5;
   localparam int ERR_W  = 3;

   // Default identifier buffer depth.
   localparam int MAX_IDENT_DEFAULT = 32;

   // Keyword tracking: four keywords, the longest has six characters.
   localparam int KW_COUNT = 4;
   localparam int KW_POS_W = 6;

   // Token kinds.
   localparam logic [KIND_W-1:0] KIND_RETURN = 5'd0;
   localparam logic [KIND_W-1:0] KIND_FOR    = 5'd1;
   localparam logic [KIND_W-1:0] KIND_IF     = 5'd2;
   localparam logic [KIND_W-1:0] KIND_U64    = 5'd3;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd4;
   localparam logic [KIND_W-1:0] KIND_LABEL  = 5'd5;
   localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd6;
   localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd7;
   localparam logic [KIND_W-1:0] KIND_STAR   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd9;
   localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd10;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd11;
   localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd12;
   localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd13;
   localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd14;
   localparam logic [KIND_W-1:0] KIND_SHL    = 5'd15;
   localparam logic [KIND_W-1:0] KIND_SHR    = 5'd16;
   localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd17;
   localparam logic [KIND_W-1:0] KIND_TILDE  = 5'd18;
   localparam logic [KIND_W-1:0] KIND_AMP    = 5'd19;
   localparam logic [KIND_W-1:0] KIND_PIPE   = 5'd20;
   localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd21;
   localparam logic [KIND_W-1:0] KIND_END    = 5'd22;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd23;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNEXPECT = 3'd1;
   localparam logic [ERR_W-1:0] ERR_BAD_LT   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_GT   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd4;

   // What the scanner is in the middle of between characters.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_WORD,
      MODE_LT,
      MODE_GT,
      MODE_HALT
   } scan_mode_type;

   // Sequencer states of the control unit.
   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_DECODE,
      ST_READ,
      ST_EMIT,
      ST_TAIL
   } ctrl_state_type;

   // One result item.
   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [NUM_W-1:0]  number_value;
      logic [BYTE_W-1:0] label_char;
      logic [ERR_W-1:0]  error_code;
      logic              last;
   } rsp_type;

   // Lookup result for operators and keywords.
   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] kind;
   } kind_hit_type;

   function automatic logic is_space(input logic [BYTE_W-1:0] c);
      return (c == " ") || (c == "\t") || (c == "\n") || (c == "\r");
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [BYTE_W-1:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // Single-character operators.
   function automatic kind_hit_type op_lookup(input logic [BYTE_W-1:0] c);
      kind_hit_type r;
      r.hit = 1'b1;
      case (c)
         "+":     r.kind = KIND_PLUS;
         "-":     r.kind = KIND_MINUS;
         "*":     r.kind = KIND_STAR;
         "/":     r.kind = KIND_SLASH;
         "(":     r.kind = KIND_LPAREN;
         ")":     r.kind = KIND_RPAREN;
         "{":     r.kind = KIND_LBRACE;
         "}":     r.kind = KIND_RBRACE;
         ";":     r.kind = KIND_SEMI;
         "=":     r.kind = KIND_ASSIGN;
         "~":     r.kind = KIND_TILDE;
         "&":     r.kind = KIND_AMP;
         "|":     r.kind = KIND_PIPE;
         ",":     r.kind = KIND_COMMA;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_ERROR;
         end
      endcase
      return r;
   endfunction

   // Keyword lengths: return, for, if, u64.
   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] n;
      case (k)
         2'd0:    n = 3'd6;
         2'd1:    n = 3'd3;
         2'd2:    n = 3'd2;
         default: n = 3'd3;
      endcase
      return n;
   endfunction

   // Character of keyword k at position pos.
   function automatic logic [BYTE_W-1:0] kw_char(input logic [1:0] k,
                                                 input logic [2:0] pos);
      logic [BYTE_W-1:0] ch;
      ch = 8'h00;
      case (k)
         2'd0: begin
            case (pos)
               3'd0:    ch = "r";
               3'd1:    ch = "e";
               3'd2:    ch = "t";
               3'd3:    ch = "u";
               3'd4:    ch = "r";
               3'd5:    ch = "n";
               default: ch = 8'h00;
            endcase
         end
         2'd1: begin
            case (pos)
               3'd0:    ch = "f";
               3'd1:    ch = "o";
               3'd2:    ch = "r";
               default: ch = 8'h00;
            endcase
         end
         2'd2: begin
            case (pos)
               3'd0:    ch = "i";
               3'd1:    ch = "f";
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               3'd0:    ch = "u";
               3'd1:    ch = "6";
               3'd2:    ch = "4";
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

   // Updates the per-keyword prefix match flags when character c is stored
   // at position pos of the word.
   function automatic logic [KW_COUNT-1:0] kw_track(input logic [KW_COUNT-1:0] ok,
                                                    input logic [KW_POS_W-1:0] pos,
                                                    input logic [BYTE_W-1:0] c);
      logic [KW_COUNT-1:0] r;
      logic                prev;
      for (int k = 0; k < KW_COUNT; k++) begin
         prev = (pos == '0) ? 1'b1 : ok[k];
         r[k] = prev && (pos < KW_POS_W'(kw_len(2'(k)))) &&
                (c == kw_char(2'(k), pos[2:0]));
      end
      return r;
   endfunction

   // A word is a keyword when every stored character matched and the
   // lengths agree.
   function automatic kind_hit_type kw_match(input logic [KW_COUNT-1:0] ok,
                                             input logic [KW_POS_W-1:0] len);
      kind_hit_type r;
      r.hit  = 1'b0;
      r.kind = KIND_RETURN;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (ok[k] && (len == KW_POS_W'(kw_len(2'(k))))) begin
            r.hit  = 1'b1;
            r.kind = KIND_W'(k);
         end
      end
      return r;
   endfunction

endpackage

[rtl/stok_req_if.sv]
// ============================================================================
// Tokenizer request channel
// Carries one source character per transfer, with the end-of-input flag.
// ============================================================================
interface stok_req_if;
   import stok_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_req;
   logic              end_of_input;

   modport source (output valid, output byte_req, output end_of_input, input ready);
   modport sink   (input valid, input byte_req, input end_of_input, output ready);
endinterface

[rtl/stok_rsp_if.sv]
// ============================================================================
// Tokenizer response channel
// Carries one token or label character per transfer.
// ============================================================================
interface stok_rsp_if;
   import stok_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [NUM_W-1:0]  number_value;
   logic [BYTE_W-1:0] label_char;
   logic [ERR_W-1:0]  error_code;
   logic              last;

   modport source (output valid, output token_kind, output number_value,
                   output label_char, output error_code, output last, input ready);
   modport sink   (input valid, input token_kind, input number_value,
                   input label_char, input error_code, input last, output ready);
endinterface

[rtl/stok_ident_mem.sv]
// ============================================================================
// Identifier buffer
// Single-port-write, single-port-read synchronous RAM holding the characters
// of the word being scanned. Read data is registered.
// ============================================================================
module stok_ident_mem #(
   parameter int DEPTH  = stok_pkg::MAX_IDENT_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [stok_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [stok_pkg::BYTE_W-1:0] rd_data
);
   import stok_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/stok_ctrl.sv]
// ============================================================================
// Tokenizer control unit
// Holds the scan state, the number accumulator and the keyword match flags,
// decodes each character and sequences the replay of buffered identifier
// characters from the identifier buffer.
// ============================================================================
module stok_ctrl #(
   parameter int MAX_IDENT = stok_pkg::MAX_IDENT_DEFAULT,
   parameter int ADDR_W    = (MAX_IDENT > 1) ? $clog2(MAX_IDENT) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [stok_pkg::BYTE_W-1:0] req_byte,
   input  logic                        req_eoi,
   input  logic                        out_free,
   output logic                        emit_valid,
   output stok_pkg::rsp_type           emit_rsp,
   output logic                        mem_we,
   output logic [ADDR_W-1:0]           mem_waddr,
   output logic [stok_pkg::BYTE_W-1:0] mem_wdata,
   output logic                        mem_re,
   output logic [ADDR_W-1:0]           mem_raddr,
   input  logic [stok_pkg::BYTE_W-1:0] mem_rdata
);
   import stok_pkg::*;

   localparam int LEN_W = $clog2(MAX_IDENT + 1);

   ctrl_state_type      state_ff, state_in;
   scan_mode_type       mode_ff, mode_in;
   logic [NUM_W-1:0]    acc_ff, acc_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [KW_COUNT-1:0] kw_ok_ff, kw_ok_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                eoi_ff, eoi_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;

   scan_mode_type       eff_mode;
   logic                c_space, c_digit, c_letter, c_lt, c_gt, c_alnum;
   kind_hit_type        op_hit;
   kind_hit_type        kw_hit;
   logic                tail_unexpected, tail_emit;
   logic [KIND_W-1:0]   tail_kind;
   logic [ERR_W-1:0]    tail_err;
   scan_mode_type       tail_mode;
   logic                rd_last;
   logic                emit_want, mem_we_want, hold;
   logic                use_tail, go_replay, go_tail;

   // Character classes of the held character.
   always_comb begin
      c_space  = is_space(byte_ff);
      c_digit  = is_digit(byte_ff);
      c_letter = is_letter(byte_ff);
      c_lt     = (byte_ff == "<");
      c_gt     = (byte_ff == ">");
      c_alnum  = c_digit || c_letter;
      op_hit   = op_lookup(byte_ff);
      kw_hit   = kw_match(kw_ok_ff, KW_POS_W'(len_ff));
   end

   // What the held character does when scanned from idle.
   always_comb begin
      tail_unexpected = !(c_space || c_digit || c_letter || c_lt || c_gt || op_hit.hit);
      tail_emit       = eoi_ff || op_hit.hit || tail_unexpected;
      tail_kind       = KIND_ERROR;
      tail_err        = ERR_NONE;
      tail_mode       = MODE_IDLE;
      if (eoi_ff) begin
         tail_kind = KIND_END;
      end else if (op_hit.hit) begin
         tail_kind = op_hit.kind;
      end else if (tail_unexpected) begin
         tail_err  = ERR_UNEXPECT;
         tail_mode = MODE_HALT;
      end else if (c_digit) begin
         tail_mode = MODE_NUM;
      end else if (c_letter) begin
         tail_mode = MODE_WORD;
      end else if (c_lt) begin
         tail_mode = MODE_LT;
      end else if (c_gt) begin
         tail_mode = MODE_GT;
      end
   end

   // The second pass of a character always starts from idle.
   assign eff_mode = (state_ff == ST_TAIL) ? MODE_IDLE : mode_ff;
   assign rd_last  = ((LEN_W'(rd_idx_ff) + LEN_W'(1)) == len_ff);

   // Decode and datapath updates.
   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      len_in      = len_ff;
      kw_ok_in    = kw_ok_ff;
      byte_in     = byte_ff;
      eoi_in      = eoi_ff;
      rd_idx_in   = rd_idx_ff;
      mem_we_want = 1'b0;
      mem_waddr   = len_ff[ADDR_W-1:0];
      mem_wdata   = byte_ff;
      mem_re      = 1'b0;
      mem_raddr   = rd_idx_ff;
      emit_want   = 1'b0;
      emit_rsp    = '0;
      use_tail    = 1'b0;
      go_replay   = 1'b0;
      go_tail     = 1'b0;
      req_ready   = (state_ff == ST_ACCEPT);

      case (state_ff)
         ST_ACCEPT: begin
            if (req_valid) begin
               byte_in = req_byte;
               eoi_in  = req_eoi;
            end
         end

         ST_DECODE, ST_TAIL: begin
            if (eff_mode == MODE_HALT) begin
               // Halted: the character is dropped.
            end else if (eoi_ff && eff_mode == MODE_LT) begin
               emit_want           = 1'b1;
               emit_rsp.token_kind = KIND_ERROR;
               emit_rsp.error_code = ERR_BAD_LT;
               emit_rsp.last       = 1'b1;
               mode_in             = MODE_HALT;
            end else if (eoi_ff && eff_mode == MODE_GT) begin
               emit_want           = 1'b1;
               emit_rsp.token_kind = KIND_ERROR;
               emit_rsp.error_code = ERR_BAD_GT;
               emit_rsp.last       = 1'b1;
               mode_in             = MODE_HALT;
            end else if (!eoi_ff && eff_mode == MODE_NUM && c_digit) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + NUM_W'(byte_ff[3:0]);
            end else if (!eoi_ff && eff_mode == MODE_WORD && c_alnum) begin
               if (len_ff >= LEN_W'(MAX_IDENT)) begin
                  emit_want           = 1'b1;
                  emit_rsp.token_kind = KIND_ERROR;
                  emit_rsp.error_code = ERR_TOO_LONG;
                  emit_rsp.last       = 1'b1;
                  mode_in             = MODE_HALT;
               end else begin
                  mem_we_want = 1'b1;
                  len_in      = len_ff + LEN_W'(1);
                  kw_ok_in    = kw_track(kw_ok_ff, KW_POS_W'(len_ff), byte_ff);
               end
            end else if (!eoi_ff && eff_mode == MODE_LT) begin
               emit_want     = 1'b1;
               emit_rsp.last = 1'b1;
               if (c_lt) begin
                  emit_rsp.token_kind = KIND_SHL;
                  mode_in             = MODE_IDLE;
               end else begin
                  emit_rsp.token_kind = KIND_ERROR;
                  emit_rsp.error_code = ERR_BAD_LT;
                  mode_in             = MODE_HALT;
               end
            end else if (!eoi_ff && eff_mode == MODE_GT) begin
               emit_want     = 1'b1;
               emit_rsp.last = 1'b1;
               if (c_gt) begin
                  emit_rsp.token_kind = KIND_SHR;
                  mode_in             = MODE_IDLE;
               end else begin
                  emit_rsp.token_kind = KIND_ERROR;
                  emit_rsp.error_code = ERR_BAD_GT;
                  mode_in             = MODE_HALT;
               end
            end else if (eff_mode == MODE_NUM || (eff_mode == MODE_WORD && kw_hit.hit)) begin
               // Pending number or keyword goes out first.
               emit_want = 1'b1;
               if (eff_mode == MODE_NUM) begin
                  emit_rsp.token_kind   = KIND_NUMBER;
                  emit_rsp.number_value = acc_ff;
               end else begin
                  emit_rsp.token_kind = kw_hit.kind;
               end
               emit_rsp.last = !tail_emit;
               if (tail_emit) begin
                  mode_in = MODE_IDLE;
                  acc_in  = '0;
                  len_in  = '0;
                  go_tail = 1'b1;
               end else begin
                  use_tail = 1'b1;
               end
            end else if (eff_mode == MODE_WORD) begin
               // Plain label: replay the buffered characters.
               go_replay = 1'b1;
               rd_idx_in = '0;
            end else begin
               // Nothing pending: scan the character from idle.
               emit_want           = tail_emit;
               emit_rsp.token_kind = tail_kind;
               emit_rsp.error_code = tail_err;
               emit_rsp.last       = 1'b1;
               use_tail            = 1'b1;
            end
         end

         ST_READ: begin
            mem_re = 1'b1;
         end

         ST_EMIT: begin
            emit_want           = 1'b1;
            emit_rsp.token_kind = KIND_LABEL;
            emit_rsp.label_char = mem_rdata;
            emit_rsp.last       = rd_last && !tail_emit;
            if (rd_last) begin
               if (tail_emit) begin
                  mode_in = MODE_IDLE;
                  acc_in  = '0;
                  len_in  = '0;
                  go_tail = 1'b1;
               end else begin
                  use_tail = 1'b1;
               end
            end else begin
               rd_idx_in = rd_idx_ff + ADDR_W'(1);
            end
         end

         default: begin
         end
      endcase

      // Scan state after the held character is handled from idle.
      if (use_tail) begin
         mode_in = tail_mode;
         acc_in  = c_digit ? NUM_W'(byte_ff[3:0]) : '0;
         len_in  = '0;
         if (!eoi_ff && c_letter) begin
            mem_we_want = 1'b1;
            mem_waddr   = '0;
            len_in      = LEN_W'(1);
            kw_ok_in    = kw_track(kw_ok_ff, '0, byte_ff);
         end
      end
   end

   // A result that cannot be handed over freezes the step.
   assign hold       = emit_want && !out_free;
   assign emit_valid = emit_want && out_free;
   assign mem_we     = mem_we_want && !hold;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE, ST_TAIL: begin
            if (hold) begin
               state_in = state_ff;
            end else if (go_replay) begin
               state_in = ST_READ;
            end else if (go_tail) begin
               state_in = ST_TAIL;
            end else begin
               state_in = ST_ACCEPT;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (hold) begin
               state_in = ST_EMIT;
            end else if (!rd_last) begin
               state_in = ST_READ;
            end else if (go_tail) begin
               state_in = ST_TAIL;
            end else begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         mode_ff  <= MODE_IDLE;
         acc_ff   <= '0;
         len_ff   <= '0;
         kw_ok_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (!hold) begin
            mode_ff  <= mode_in;
            acc_ff   <= acc_in;
            len_ff   <= len_in;
            kw_ok_ff <= kw_ok_in;
         end
      end
   end

   // Held character and replay index.
   always_ff @(posedge clock) begin
      if (!hold) begin
         byte_ff   <= byte_in;
         eoi_ff    <= eoi_in;
         rd_idx_ff <= rd_idx_in;
      end
   end
endmodule

[rtl/source_tokenizer.sv]
// ============================================================================
// Source tokenizer
// A character is taken in the accept state, decoded in the decode state and
// its result registered in the output register. A pending number or keyword
// followed by an emitting character also goes through the tail state. A label
// replays each buffered character through the read and emit states, since the
// buffer read is registered, plus the tail state when its delimiter emits
// a result of its own. A new character waits until the last is handled.
// Reset (synchronous) clears the scan state; the buffer is not cleared.
// ============================================================================
module source_tokenizer #(
   parameter int MAX_IDENT = stok_pkg::MAX_IDENT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   stok_req_if.sink    req_chan,
   stok_rsp_if.source  rsp_chan
);
   import stok_pkg::*;

   localparam int ADDR_W = (MAX_IDENT > 1) ? $clog2(MAX_IDENT) : 1;

   logic              out_free;
   logic              emit_valid;
   rsp_type           emit_rsp;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   stok_ctrl #(
      .MAX_IDENT (MAX_IDENT),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_byte   (req_chan.byte_req),
      .req_eoi    (req_chan.end_of_input),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_rsp   (emit_rsp),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   stok_ident_mem #(
      .DEPTH  (MAX_IDENT),
      .ADDR_W (ADDR_W)
   ) u_ident_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // The output register is free when empty or when its transfer completes.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_data_ff <= emit_rsp;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.token_kind   = rsp_data_ff.token_kind;
   assign rsp_chan.number_value = rsp_data_ff.number_value;
   assign rsp_chan.label_char   = rsp_data_ff.label_char;
   assign rsp_chan.error_code   = rsp_data_ff.error_code;
   assign rsp_chan.last         = rsp_data_ff.last;
endmodule

[test/source_tokenizer_tb.sv]
// ============================================================================
// Source tokenizer testbench
// Streams source characters through the tokenizer and checks every token
// against a predictor kept in step with the accepted characters. A short
// table of hand-picked characters comes first. Random but well-formed source
// text follows, and one randomly chosen error closes the run, since an error
// halts the block until reset. Both sides idle at random. Once, the receiver
// holds off long enough for the block to back up into its input.
// ============================================================================
module source_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stok_pkg::*;

   localparam int WORD_MAX     = MAX_IDENT_DEFAULT;
   localparam int RANDOM_CHARS = 400;
   localparam int HOLD_AFTER   = 120;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 200;

   // One row of the directed character list.
   typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              eoi;
      bit                typed;
      rsp_type           tok;
   } plan_row_type;

   logic clock;
   logic reset;

   stok_req_if req_chan ();
   stok_rsp_if rsp_chan ();

   source_tokenizer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state, a copy of what the scanner keeps between characters.
   scan_mode_type     mode_q;
   logic [NUM_W-1:0]  num_acc;
   logic [BYTE_W-1:0] word_buf [WORD_MAX];
   int                word_len;

   // Tokens caused by the latest character, and tokens still owed by the block.
   rsp_type step_tokens[$];
   rsp_type expected_tokens[$];
   plan_row_type plan_rows[$];

   string kw_text [4] = '{"return", "for", "if", "u64"};
   logic [KIND_W-1:0] kw_kinds [4] = '{KIND_RETURN, KIND_FOR, KIND_IF, KIND_U64};
   string kw_traps [14] = '{"return", "for", "if", "u64", "retur", "returns", "fo",
                            "form", "i", "iff", "u6", "u640", "IF", "For"};
   string op_chars = "+-*/(){};=~&|,";
   string blanks   = " \t\n\r";

   int   chars_sent  = 0;
   int   tokens_seen = 0;
   int   mismatches  = 0;
   int   cycle_count = 0;
   logic hold_rsp;

   // Character classes of the source language.
   function automatic bit blank_char(input logic [BYTE_W-1:0] ch);
      return ch == " " || ch == "\t" || ch == "\n" || ch == "\r";
   endfunction

   function automatic bit digit_char(input logic [BYTE_W-1:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic bit alpha_char(input logic [BYTE_W-1:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   // Token kind of a single-character operator; hit is low for other bytes.
   function automatic logic [KIND_W-1:0] op_code(input logic [BYTE_W-1:0] ch,
                                                 output bit hit);
      hit = 1'b1;
      case (ch)
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         ";":     return KIND_SEMI;
         "=":     return KIND_ASSIGN;
         "~":     return KIND_TILDE;
         "&":     return KIND_AMP;
         "|":     return KIND_PIPE;
         ",":     return KIND_COMMA;
         default: begin
            hit = 1'b0;
            return KIND_ERROR;
         end
      endcase
   endfunction

   function automatic void put_token(input logic [KIND_W-1:0] kind,
                                     input logic [NUM_W-1:0] num,
                                     input logic [BYTE_W-1:0] ch,
                                     input logic [ERR_W-1:0] code);
      rsp_type t;
      t.token_kind   = kind;
      t.number_value = num;
      t.label_char   = ch;
      t.error_code   = code;
      t.last         = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void raise_error(input logic [ERR_W-1:0] code);
      mode_q = MODE_HALT;
      put_token(KIND_ERROR, '0, '0, code);
   endfunction

   // Emits the number or word in progress and returns the scanner to idle.
   function automatic void flush_pending();
      int kw;
      bit same;
      kw = -1;
      if (mode_q == MODE_NUM) begin
         put_token(KIND_NUMBER, num_acc, '0, ERR_NONE);
      end else if (mode_q == MODE_WORD) begin
         for (int k = 0; k < 4; k++) begin
            if (kw < 0 && kw_text[k].len() == word_len) begin
               same = 1'b1;
               for (int i = 0; i < word_len; i++) begin
                  if (word_buf[i] != kw_text[k][i]) same = 1'b0;
               end
               if (same) kw = k;
            end
         end
         if (kw >= 0) begin
            put_token(kw_kinds[kw], '0, '0, ERR_NONE);
         end else begin
            for (int i = 0; i < word_len; i++) put_token(KIND_LABEL, '0, word_buf[i], ERR_NONE);
         end
      end
      mode_q  = MODE_IDLE;
      num_acc = '0;
      word_len = 0;
   endfunction

   // Works out the tokens that one accepted character causes.
   function automatic void predict_char(input logic [BYTE_W-1:0] ch, input logic eoi);
      logic [KIND_W-1:0] op;
      bit                op_hit;
      rsp_type           t;
      step_tokens.delete();
      op = op_code(ch, op_hit);
      if (mode_q == MODE_HALT) return;
      if (eoi) begin
         if (mode_q == MODE_LT) begin
            raise_error(ERR_BAD_LT);
         end else if (mode_q == MODE_GT) begin
            raise_error(ERR_BAD_GT);
         end else begin
            flush_pending();
            put_token(KIND_END, '0, '0, ERR_NONE);
         end
      end else if (mode_q == MODE_NUM && digit_char(ch)) begin
         num_acc = num_acc * 64'd10 + NUM_W'(ch - "0");
      end else if (mode_q == MODE_WORD && (alpha_char(ch) || digit_char(ch))) begin
         if (word_len >= WORD_MAX) begin
            raise_error(ERR_TOO_LONG);
         end else begin
            word_buf[word_len] = ch;
            word_len++;
         end
      end else if (mode_q == MODE_LT) begin
         if (ch == "<") begin
            mode_q = MODE_IDLE;
            put_token(KIND_SHL, '0, '0, ERR_NONE);
         end else begin
            raise_error(ERR_BAD_LT);
         end
      end else if (mode_q == MODE_GT) begin
         if (ch == ">") begin
            mode_q = MODE_IDLE;
            put_token(KIND_SHR, '0, '0, ERR_NONE);
         end else begin
            raise_error(ERR_BAD_GT);
         end
      end else begin
         // A delimiter ends the pending token and is then scanned from idle.
         flush_pending();
         if (digit_char(ch)) begin
            mode_q  = MODE_NUM;
            num_acc = NUM_W'(ch - "0");
         end else if (alpha_char(ch)) begin
            mode_q      = MODE_WORD;
            word_buf[0] = ch;
            word_len    = 1;
         end else if (ch == "<") begin
            mode_q = MODE_LT;
         end else if (ch == ">") begin
            mode_q = MODE_GT;
         end else if (op_hit) begin
            put_token(op, '0, '0, ERR_NONE);
         end else if (!blank_char(ch)) begin
            raise_error(ERR_UNEXPECT);
         end
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
   endfunction

   // Directed rows whose single token is written out by hand.
   function automatic void plan_typed(input logic [BYTE_W-1:0] ch, input logic eoi,
                                      input logic [KIND_W-1:0] kind,
                                      input logic [NUM_W-1:0] num);
      plan_row_type row;
      row.ch    = ch;
      row.eoi   = eoi;
      row.typed = 1'b1;
      row.tok   = '{token_kind: kind, number_value: num, label_char: '0,
                    error_code: ERR_NONE, last: 1'b1};
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_free(input logic [BYTE_W-1:0] ch, input logic eoi);
      plan_row_type row;
      row.ch    = ch;
      row.eoi   = eoi;
      row.typed = 1'b0;
      row.tok   = '0;
      plan_rows.push_back(row);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_alnum(input bit with_digits);
      int v;
      v = $urandom_range(0, with_digits ? 61 : 51);
      if (v < 26) return BYTE_W'("a" + v);
      if (v < 52) return BYTE_W'("A" + v - 26);
      return BYTE_W'("0" + v - 52);
   endfunction

   // Offers one character after a random gap and records what it should cause.
   task automatic send_char(input logic [BYTE_W-1:0] ch, input logic eoi,
                            input bit typed, input rsp_type tok);
      int gap;
      gap = (hold_rsp || (chars_sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.byte_req     <= ch;
      req_chan.end_of_input <= eoi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
      predict_char(ch, eoi);
      if (typed) begin
         expected_tokens.push_back(tok);
      end else begin
         foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      end
   endtask

   task automatic send_plain(input logic [BYTE_W-1:0] ch);
      send_char(ch, 1'b0, 1'b0, '0);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_plain(s[i]);
   endtask

   task automatic compare_field(input string name, input logic [NUM_W-1:0] want,
                                input logic [NUM_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         // Only the first reports are printed to keep the log short.
         if (mismatches <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit in case the block stops making progress.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("source_tokenizer verification failed");
      $finish;
   end

   // One long receiver hold-off while the sender keeps offering characters.
   initial begin : rsp_hold
      hold_rsp <= 1'b0;
      while (chars_sent < HOLD_AFTER) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Receiver: checks each token transfer and stalls at random between them.
   initial begin : rsp_side
      int      stall;
      rsp_type want;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("token_kind %0d arrived with nothing expected", rsp_chan.token_kind);
            end else begin
               want = expected_tokens.pop_front();
               compare_field("token_kind", NUM_W'(want.token_kind),
                             NUM_W'(rsp_chan.token_kind));
               compare_field("number_value", want.number_value, rsp_chan.number_value);
               compare_field("label_char", NUM_W'(want.label_char),
                             NUM_W'(rsp_chan.label_char));
               compare_field("error_code", NUM_W'(want.error_code),
                             NUM_W'(rsp_chan.error_code));
               compare_field("last", NUM_W'(want.last), NUM_W'(rsp_chan.last));
            end
            stall = ((tokens_seen / 64) % 4 == 2) ? 0 : $urandom_range(0, 19);
         end
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Stimulus: directed rows, random source text, then one closing error.
   initial begin : stimulus
      int                pick;
      int                len;
      int                sel;
      bit                after_alnum;
      bit                hit;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] lead;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.byte_req     <= '0;
      req_chan.end_of_input <= 1'b0;
      mode_q   = MODE_IDLE;
      num_acc  = '0;
      word_len = 0;
      after_alnum = 1'b0;

      // End of input straight after reset, every operator, both shifts,
      // a keyword, a number, and a label closed by end of input.
      plan_typed(8'h00, 1'b1, KIND_END, '0);
      plan_typed("+", 1'b0, KIND_PLUS, '0);
      plan_typed("-", 1'b0, KIND_MINUS, '0);
      plan_typed("*", 1'b0, KIND_STAR, '0);
      plan_typed("/", 1'b0, KIND_SLASH, '0);
      plan_typed("(", 1'b0, KIND_LPAREN, '0);
      plan_typed(")", 1'b0, KIND_RPAREN, '0);
      plan_typed("{", 1'b0, KIND_LBRACE, '0);
      plan_typed("}", 1'b0, KIND_RBRACE, '0);
      plan_typed(";", 1'b0, KIND_SEMI, '0);
      plan_typed("=", 1'b0, KIND_ASSIGN, '0);
      plan_typed("~", 1'b0, KIND_TILDE, '0);
      plan_typed("&", 1'b0, KIND_AMP, '0);
      plan_typed("|", 1'b0, KIND_PIPE, '0);
      plan_typed(",", 1'b0, KIND_COMMA, '0);
      plan_free("<", 1'b0);
      plan_typed("<", 1'b0, KIND_SHL, '0);
      plan_free(">", 1'b0);
      plan_typed(">", 1'b0, KIND_SHR, '0);
      plan_free("i", 1'b0);
      plan_free("f", 1'b0);
      plan_typed(" ", 1'b0, KIND_IF, '0);
      plan_free("9", 1'b0);
      plan_typed("\t", 1'b0, KIND_NUMBER, 64'd9);
      plan_free("z", 1'b0);
      plan_free("0", 1'b0);
      plan_free(8'hFF, 1'b1);
      plan_typed(8'h80, 1'b1, KIND_END, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i])
         send_char(plan_rows[i].ch, plan_rows[i].eoi, plan_rows[i].typed, plan_rows[i].tok);

      // Random source text: words, numbers, operators, blanks and end marks.
      while (chars_sent < plan_rows.size() + RANDOM_CHARS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // Keep adjacent words and numbers apart so words stay in bounds.
            if (after_alnum) send_plain(blanks[$urandom_range(0, 3)]);
            if (pick < 25) begin
               sel = $urandom_range(0, 9);
               if (sel < 2) begin
                  send_text(kw_traps[$urandom_range(0, 13)]);
               end else begin
                  len = (sel == 2) ? WORD_MAX :
                        (sel == 3) ? $urandom_range(20, WORD_MAX - 1) : $urandom_range(1, 8);
                  send_plain(rand_alnum(1'b0));
                  repeat (len - 1) send_plain(rand_alnum(1'b1));
               end
            end else begin
               // Long digit runs wrap the value around 2^64.
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 6);
               repeat (len) send_plain(BYTE_W'("0" + $urandom_range(0, 9)));
            end
            after_alnum = 1'b1;
         end else begin
            after_alnum = 1'b0;
            if (pick < 70) begin
               send_plain(op_chars[$urandom_range(0, 13)]);
            end else if (pick < 78) begin
               lead = $urandom_range(0, 1) ? "<" : ">";
               send_plain(lead);
               send_plain(lead);
            end else if (pick < 95) begin
               send_plain(blanks[$urandom_range(0, 3)]);
            end else begin
               send_char(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            end
         end
      end

      // An error halts the block for good, so only one kind closes each run.
      sel = $urandom_range(0, 5);
      if (sel == 0) begin
         do begin
            b = BYTE_W'($urandom_range(0, 255));
            void'(op_code(b, hit));
         end while (hit || blank_char(b) || digit_char(b) || alpha_char(b) ||
                    b == "<" || b == ">");
         send_plain(b);
      end else if (sel <= 4) begin
         lead = (sel % 2 == 1) ? "<" : ">";
         send_plain(lead);
         if (sel <= 2) begin
            do b = BYTE_W'($urandom_range(0, 255)); while (b == lead);
            send_plain(b);
         end else begin
            send_char(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
         end
      end else begin
         if (after_alnum) send_plain(" ");
         send_plain(rand_alnum(1'b0));
         repeat (WORD_MAX) send_plain(rand_alnum(1'b1));
      end

      // Characters after the error must produce nothing.
      repeat (6) send_char(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      req_chan.valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("source_tokenizer verification clean");
      end else begin
         $display("source_tokenizer verification failed");
      end
      $finish;
   end

endmodule

[source_tokenizer.f]
rtl/stok_pkg.sv
rtl/stok_req_if.sv
rtl/stok_rsp_if.sv
rtl/stok_ident_mem.sv
rtl/stok_ctrl.sv
rtl/source_tokenizer.sv
test/source_tokenizer_tb.sv
